[rtl/shift_register_multichannel_pwm_assert.svh]
// ----------------------------------------------------------------------------
// shift register pwm assertion macros
// clocked on clk_i; the plain form is disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SHIFT_REGISTER_MULTICHANNEL_PWM_ASSERT_SVH
`define SHIFT_REGISTER_MULTICHANNEL_PWM_ASSERT_SVH

// property checked only out of reset
`define SRPWM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every edge, reset included
`define SRPWM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/srpwm_pkg.sv]
// ----------------------------------------------------------------------------
// srpwm_pkg
// shared widths, codes and reset values of the shift register pwm block
// ----------------------------------------------------------------------------
`default_nettype none

package srpwm_pkg;

  // field widths
  localparam int unsigned CHAN_W      = 6;
  localparam int unsigned DUTY_W      = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned RES_W       = 8;
  localparam int unsigned LANE_IDX_W  = 3;
  localparam int unsigned LANES       = 8;
  localparam int unsigned ROW_W       = LANES * DUTY_W;

  // stream packing
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION     = 1'd1;

  // operation codes
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // defaults
  localparam int unsigned DEF_MAX_REGISTERS = 8;
  localparam logic [COUNT_W-1:0] RST_REGISTER_COUNT = 4'd1;
  localparam logic [RES_W-1:0]   RST_RESOLUTION     = 8'd255;

  // rounding offset for the duty scaling
  localparam logic [2*DUTY_W-1:0] SCALE_ROUND = 16'd128;

endpackage

`default_nettype wire

[rtl/srpwm_ram.sv]
// ----------------------------------------------------------------------------
// srpwm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module srpwm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/shift_register_multichannel_pwm.sv]
// ----------------------------------------------------------------------------
// shift_register_multichannel_pwm
// pwm pattern generator for a chain of 8-bit shift registers, 8 channels each
// ----------------------------------------------------------------------------
// Input stream: s_axis beats carry a set (tuser = 0: channel and duty) or a
// tick (tuser = 1). A set scales the duty to the resolution, rounded, and
// stores it; a set for a register beyond the chain is dropped. A set reads
// the channel's ram row, then merges and writes it; a dropped set does neither.
// Output stream: a tick yields one m_axis beat per register in use, highest
// register first; tlast marks register 0, the beat that should pulse latch.
// The first byte passes the ram read register and the output register, then
// one byte a cycle while the receiver is ready; the input waits until the
// tick's last byte is loaded. The rate is set by the single ram read port:
// one 64-bit row (one register, eight levels compared in parallel) per cycle.
// The output register parts the two sides: the next item is taken while the
// last byte of a tick still waits. When the receiver stalls, the byte holds
// and the row is read again each cycle until the beat is taken. Reset: levels
// read as zero (row valid flags cleared), slot counter zero, one register,
// 255 slots. The user must write configuration only while idle (unenforced).
// ----------------------------------------------------------------------------
`default_nettype none

`include "shift_register_multichannel_pwm_assert.svh"

module shift_register_multichannel_pwm
  import srpwm_pkg::*;
#(
  parameter int unsigned MAX_REGISTERS = DEF_MAX_REGISTERS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: channel [5:0], duty [13:6], zero [15:14]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: operation [0]
  input  wire logic [0:0]             s_axis_tuser,
  // output stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata: shift_byte [7:0], register_index [10:8], zero [15:11]
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast
);

  localparam int unsigned AW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SET  = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;

  // configuration registers
  logic [COUNT_W-1:0] cfg_count_q;
  logic [RES_W-1:0]   cfg_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= RST_REGISTER_COUNT;
      cfg_res_q   <= RST_RESOLUTION;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REGISTER_COUNT: cfg_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_RESOLUTION:     cfg_res_q   <= cfg_data_i[RES_W-1:0];
        default:            cfg_count_q <= cfg_count_q;
      endcase
    end
  end

  // effective register count, clamped to 1..MAX_REGISTERS
  logic [COUNT_W-1:0]   eff_count;
  logic [REG_IDX_W-1:0] count_m1;

  always_comb begin
    if (cfg_count_q == '0) begin
      eff_count = COUNT_W'(1);
    end else if (cfg_count_q > COUNT_W'(MAX_REGISTERS)) begin
      eff_count = COUNT_W'(MAX_REGISTERS);
    end else begin
      eff_count = cfg_count_q;
    end
  end

  assign count_m1 = REG_IDX_W'(eff_count - COUNT_W'(1));

  // input beat fields
  logic                 in_op;
  logic [CHAN_W-1:0]    in_ch;
  logic [DUTY_W-1:0]    in_duty;
  logic                 in_fire;
  logic                 set_in_range;

  assign in_op        = s_axis_tuser[0];
  assign in_ch        = s_axis_tdata[CHAN_W-1:0];
  assign in_duty      = s_axis_tdata[CHAN_W+DUTY_W-1:CHAN_W];
  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign set_in_range = {1'b0, in_ch[CHAN_W-1:LANE_IDX_W]} < eff_count;

  // control state
  logic [1:0]             state_q, state_d;
  logic [REG_IDX_W-1:0]   rd_q, rd_d;
  logic [MAX_REGISTERS-1:0] row_valid_q, row_valid_d;
  logic [RES_W-1:0]       slot_q, slot_d;
  logic                   out_valid_q, out_valid_d;

  // payload of a pending set
  logic [CHAN_W-1:0]      ch_q, ch_d;
  logic [DUTY_W-1:0]      duty_q, duty_d;

  // output beat register
  logic [BYTE_W-1:0]      out_byte_q;
  logic [REG_IDX_W-1:0]   out_idx_q;
  logic                   out_last_q;

  // ram interface
  logic                   ram_we;
  logic [REG_IDX_W-1:0]   raddr;
  logic [ROW_W-1:0]       ram_rdata;
  logic [ROW_W-1:0]       ram_wdata;
  logic [AW-1:0]          set_row;
  logic [AW-1:0]          rd_row;

  assign set_row = ch_q[LANE_IDX_W+AW-1:LANE_IDX_W];
  assign rd_row  = rd_q[AW-1:0];

  srpwm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_REGISTERS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_row),
    .wdata_i (ram_wdata),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // duty scaling, round half up
  logic [2*DUTY_W-1:0] scale_sum;
  logic [DUTY_W-1:0]   scaled;

  assign scale_sum = ({{DUTY_W{1'b0}}, duty_q} * {{(2*DUTY_W-RES_W){1'b0}}, cfg_res_q})
                     + SCALE_ROUND;
  assign scaled    = scale_sum[2*DUTY_W-1:DUTY_W];

  // row merge: replace one lane, unwritten rows start from zero
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      if (ch_q[LANE_IDX_W-1:0] == LANE_IDX_W'(b)) begin
        ram_wdata[b*DUTY_W +: DUTY_W] = scaled;
      end else if (row_valid_q[set_row]) begin
        ram_wdata[b*DUTY_W +: DUTY_W] = ram_rdata[b*DUTY_W +: DUTY_W];
      end else begin
        ram_wdata[b*DUTY_W +: DUTY_W] = '0;
      end
    end
  end

  // compare the eight levels of the current row against the slot
  logic [BYTE_W-1:0] cmp_byte;

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      cmp_byte[b] = row_valid_q[rd_row] && (ram_rdata[b*DUTY_W +: DUTY_W] > slot_q);
    end
  end

  // slot advance with wrap at the period
  logic [RES_W:0] period;
  logic [RES_W:0] slot_inc;
  logic [RES_W-1:0] slot_next;

  assign period    = (cfg_res_q == '0) ? {1'b1, {RES_W{1'b0}}} : {1'b0, cfg_res_q};
  assign slot_inc  = {1'b0, slot_q} + (RES_W+1)'(1);
  assign slot_next = (slot_inc >= period) ? '0 : slot_inc[RES_W-1:0];

  // sequencer
  logic out_free;
  logic out_load;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    rd_d        = rd_q;
    raddr       = rd_q;
    ch_d        = ch_q;
    duty_d      = duty_q;
    ram_we      = 1'b0;
    row_valid_d = row_valid_q;
    slot_d      = slot_q;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_TICK) begin
            raddr   = count_m1;
            rd_d    = count_m1;
            state_d = ST_TICK;
          end else if (set_in_range) begin
            raddr   = in_ch[CHAN_W-1:LANE_IDX_W];
            ch_d    = in_ch;
            duty_d  = in_duty;
            state_d = ST_SET;
          end
        end
      end
      ST_SET: begin
        ram_we               = 1'b1;
        row_valid_d[set_row] = 1'b1;
        state_d              = ST_IDLE;
      end
      ST_TICK: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rd_q == '0) begin
            slot_d  = slot_next;
            state_d = ST_IDLE;
          end else begin
            rd_d  = REG_IDX_W'(rd_q - REG_IDX_W'(1));
            raddr = REG_IDX_W'(rd_q - REG_IDX_W'(1));
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // output valid follows loads and accepted beats
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_q        <= '0;
      row_valid_q <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      row_valid_q <= row_valid_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    duty_q <= duty_d;
    if (out_load) begin
      out_byte_q <= cmp_byte;
      out_idx_q  <= rd_q;
      out_last_q <= (rd_q == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-BYTE_W-REG_IDX_W){1'b0}}, out_idx_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

  // checks
  `SRPWM_ASSERT(a_last_is_reg0, (m_axis_tvalid && m_axis_tlast) |-> (out_idx_q == '0), "latch beat not on register 0")
  `SRPWM_ASSERT(a_rd_in_chain, (state_q == ST_TICK) |-> (rd_q <= count_m1), "tick reads beyond the chain")
  `SRPWM_ASSERT(a_set_in_chain, ram_we |-> ({1'b0, ch_q[CHAN_W-1:LANE_IDX_W]} < eff_count), "set writes beyond the chain")
  `SRPWM_ASSERT(a_tick_ends, (state_q == ST_TICK && out_load && rd_q == '0) |=> (state_q == ST_IDLE && m_axis_tvalid), "tick did not end on its last beat")
  `SRPWM_ASSERT_ALWAYS(a_ready_idle, s_axis_tready |-> (state_q == ST_IDLE), "input taken while busy")

endmodule

`default_nettype wire

[bench/tb_shift_register_multichannel_pwm.sv]
// ----------------------------------------------------------------------------
// tb_shift_register_multichannel_pwm
// self-checking bench for the shift register pwm pattern generator
// ----------------------------------------------------------------------------
// Drives set and tick items into the input stream and collects output beats.
// A behavioral tracker keeps its own copy of the channel levels, slot counter
// and chain settings, and turns every accepted tick into the byte beats it
// should produce. Each output beat is checked in order against those. The run
// starts with directed items, then random phases over several chain lengths
// and resolutions, with random gaps on the input and back-pressure on output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import srpwm_pkg::*;

// one expected output beat
typedef struct {
  logic [BYTE_W-1:0]    pattern;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 latch;
} shift_beat_t;

// levels, slot counter and chain settings, plus the bytes still owed
class pwm_pattern_tracker;
  logic [DUTY_W-1:0]  level [64];
  logic [RES_W-1:0]   slot;
  logic [RES_W-1:0]   slots;
  logic [COUNT_W-1:0] chain_len;
  shift_beat_t        pending_beats [$];
  int unsigned        mismatches;
  int unsigned        bytes_seen;
  int unsigned        sets;
  int unsigned        dropped;
  int unsigned        ticks;

  function new();
    foreach (level[i]) level[i] = '0;
    slot       = '0;
    slots      = RST_RESOLUTION;
    chain_len  = RST_REGISTER_COUNT;
    mismatches = 0;
    bytes_seen = 0;
    sets       = 0;
    dropped    = 0;
    ticks      = 0;
  endfunction

  // registers actually driven, out-of-range counts clamped
  function int unsigned span();
    int unsigned n;
    n = chain_len;
    if (n < 1) n = 1;
    if (n > DEF_MAX_REGISTERS) n = DEF_MAX_REGISTERS;
    return n;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_REGISTER_COUNT) begin
      chain_len = data[COUNT_W-1:0];
    end else begin
      slots = data[RES_W-1:0];
    end
  endfunction

  // update state for one accepted item, queue the bytes of a tick
  function void note_item(logic op, logic [CHAN_W-1:0] ch, logic [DUTY_W-1:0] duty);
    int unsigned n;
    int unsigned period;
    int unsigned nxt;
    logic [15:0] prod;
    shift_beat_t beat;
    n = span();
    if (op == OP_SET) begin
      sets++;
      if ((ch >> 3) < n) begin
        // round half up of duty / 256 * slots
        prod = 16'(duty) * 16'(slots) + 16'd128;
        level[ch] = prod[15:8];
      end else begin
        dropped++;
      end
    end else begin
      ticks++;
      for (int r = n - 1; r >= 0; r--) begin
        for (int b = 0; b < 8; b++) beat.pattern[b] = (level[r * 8 + b] > slot);
        beat.reg_idx = 3'(r);
        beat.latch   = (r == 0);
        pending_beats.push_back(beat);
      end
      // advance and wrap, also when the slot sits past a lowered period
      period = (slots == 0) ? 256 : slots;
      nxt = slot + 1;
      if (nxt >= period) nxt = 0;
      slot = 8'(nxt);
    end
  endfunction

  function void flag(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on byte %0d: %s expected %0h got %0h", bytes_seen, what, want, got);
  endfunction

  // compare one output beat with the oldest owed byte
  function void check_beat(logic [OUT_TDATA_W-1:0] data, logic last);
    shift_beat_t want;
    bytes_seen++;
    if (pending_beats.size() == 0) begin
      flag("unexpected beat, tdata", 0, data);
      return;
    end
    want = pending_beats.pop_front();
    if (data[BYTE_W-1:0] !== want.pattern) flag("shift_byte", want.pattern, data[BYTE_W-1:0]);
    if (data[BYTE_W +: REG_IDX_W] !== want.reg_idx)
      flag("register_index", want.reg_idx, data[BYTE_W +: REG_IDX_W]);
    if (data[OUT_TDATA_W-1:BYTE_W+REG_IDX_W] !== '0)
      flag("tdata padding", 0, data[OUT_TDATA_W-1:BYTE_W+REG_IDX_W]);
    if (last !== want.latch) flag("latch", want.latch, last);
  endfunction
endclass

module tb_shift_register_multichannel_pwm;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS   = 20;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  pwm_pattern_tracker tracker = new();
  bit                 no_idle = 1'b0;
  int unsigned        cycles  = 0;
  int unsigned        settings_seen = 0;

  shift_register_multichannel_pwm i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("shift_register_multichannel_pwm regression: fail");
      $finish;
    end
  end

  // output side: check taken beats, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_beat(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 13);
  end

  // offer one item, hold it until taken
  task automatic push_item(input logic op, input logic [CHAN_W-1:0] ch,
                           input logic [DUTY_W-1:0] duty);
    while (!no_idle && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, duty, ch};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_item(op, ch, duty);
  endtask

  task automatic tick_slot();
    push_item(OP_TICK, CHAN_W'($urandom), DUTY_W'($urandom));
  endtask

  // stop sending, wait for every owed byte and let a trailing set finish
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both registers, only while idle
  task automatic program_chain(input logic [CFG_DATA_W-1:0] count_word,
                               input logic [CFG_DATA_W-1:0] slot_word);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_REGISTER_COUNT;
    cfg_data_i <= count_word;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RESOLUTION;
    cfg_data_i <= slot_word;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.write_register(CFG_REGISTER_COUNT, count_word);
    tracker.write_register(CFG_RESOLUTION, slot_word);
    settings_seen++;
  endtask

  initial begin
    int unsigned counted;
    int unsigned pick;
    logic [CHAN_W-1:0] ch;
    logic [DUTY_W-1:0] duty;
    logic [CFG_DATA_W-1:0] count_word;
    logic [CFG_DATA_W-1:0] slot_word;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one register, 255 slots; sets past the chain are dropped
    tick_slot();
    push_item(OP_SET, 6'd0, 8'd255);
    push_item(OP_SET, 6'd7, 8'd128);
    push_item(OP_SET, 6'd8, 8'd200);
    push_item(OP_SET, 6'd63, 8'd255);
    tick_slot();
    tick_slot();
    drain_results();

    // full chain, alternating bit patterns in channel and duty
    program_chain(8'd8, 8'd255);
    push_item(OP_SET, 6'd63, 8'd255);
    push_item(OP_SET, 6'd56, 8'd1);
    push_item(OP_SET, 6'd32, 8'd64);
    push_item(OP_SET, 6'd42, 8'd170);
    push_item(OP_SET, 6'd21, 8'd85);
    tick_slot();
    drain_results();

    // period lowered to the slot value: old levels kept, counter wraps
    program_chain(8'd8, 8'd4);
    tick_slot();
    push_item(OP_SET, 6'd1, 8'd200);
    tick_slot();
    tick_slot();
    drain_results();

    // count zero acts as one, zero resolution stores level zero
    program_chain(8'd0, 8'd0);
    push_item(OP_SET, 6'd0, 8'd255);
    push_item(OP_SET, 6'd9, 8'd255);
    tick_slot();
    drain_results();

    // upper data bits ignored for the count, single slot period
    program_chain(8'h93, 8'd1);
    push_item(OP_SET, 6'd5, 8'd255);
    push_item(OP_SET, 6'd4, 8'd127);
    push_item(OP_SET, 6'd23, 8'd128);
    push_item(OP_SET, 6'd24, 8'd255);
    tick_slot();
    drain_results();

    // count above the maximum acts as the maximum
    program_chain(8'd15, 8'd255);
    tick_slot();
    drain_results();

    // random phases over extreme and random settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          count_word = 8'd8;
          slot_word  = 8'd255;
        end
        1: begin
          count_word = 8'd1;
          slot_word  = 8'd1;
        end
        2: begin
          count_word = 8'd0;
          slot_word  = 8'd0;
        end
        3: begin
          count_word = 8'd15;
          slot_word  = CFG_DATA_W'($urandom_range(1, 255));
        end
        default: begin
          count_word = CFG_DATA_W'($urandom_range(0, 15));
          slot_word  = CFG_DATA_W'($urandom_range(0, 255));
        end
      endcase
      program_chain(count_word, slot_word);
      // one phase runs with no gaps on either side
      no_idle = (p == 4);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if (p == 3 && counted == PHASE_ITEMS / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          if (pick < 48) begin
            ch = {3'($urandom_range(0, tracker.span() - 1)), 3'($urandom)};
          end else begin
            ch = CHAN_W'($urandom);
          end
          case ($urandom_range(0, 9))
            0:       duty = 8'd0;
            1:       duty = 8'd255;
            default: duty = DUTY_W'($urandom);
          endcase
          if ((ch >> 3) < tracker.span()) counted++;
          push_item(OP_SET, ch, duty);
        end else begin
          counted++;
          tick_slot();
        end
      end
      drain_results();
      no_idle = 1'b0;
    end

    $display("ran %0d sets (%0d past the chain) and %0d ticks over %0d chain settings",
             tracker.sets, tracker.dropped, tracker.ticks, settings_seen);
    $display("checked %0d output bytes, %0d mismatches",
             tracker.bytes_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_beats.size() == 0) begin
      $display("shift_register_multichannel_pwm regression: pass");
    end else begin
      $display("shift_register_multichannel_pwm regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/srpwm_pkg.sv
rtl/srpwm_ram.sv
rtl/shift_register_multichannel_pwm.sv
bench/tb_shift_register_multichannel_pwm.sv
